### rtl/itrt_pkg.sv
`timescale 1ns / 1ps
package itrt_pkg;

  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;

  // format_flags bit positions
  localparam int FLAG_UNSIGNED = 0;
  localparam int FLAG_LOWER    = 1;

  typedef struct packed {
    logic [RADIX_W-1:0] base;
    logic               neg;
    logic               lower;
  } itrt_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SIGN,
    BK_READ,
    BK_EMIT
  } back_state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic lower);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + ext;
    end else if (lower) begin
      digit_char = CHAR_LOW_A + ext - 8'd10;
    end else begin
      digit_char = CHAR_UP_A + ext - 8'd10;
    end
  endfunction

endpackage

### rtl/itrt_front.sv
`timescale 1ns / 1ps
module itrt_front import itrt_pkg::*; #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic [31:0]             number_bits,
  input  logic [RADIX_W-1:0]      radix,
  input  logic [1:0]              format_flags,
  output logic [NUMBER_WIDTH-1:0] mag,
  output itrt_cmd_t               cmd
);

  logic [NUMBER_WIDTH-1:0] bits;
  logic                    neg;

  assign bits = NUMBER_WIDTH'(number_bits);
  assign neg  = !format_flags[FLAG_UNSIGNED] && bits[NUMBER_WIDTH-1];
  assign mag  = neg ? (~bits + 1'b1) : bits;

  always_comb begin
    if (radix < RADIX_MIN) begin
      cmd.base = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      cmd.base = RADIX_MAX;
    end else begin
      cmd.base = radix;
    end
    cmd.neg   = neg;
    cmd.lower = format_flags[FLAG_LOWER];
  end

endmodule

### rtl/itrt_queue.sv
`timescale 1ns / 1ps
module itrt_queue #(
  parameter int DATA_W = 39
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] slot_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/itrt_back.sv
`timescale 1ns / 1ps
module itrt_back import itrt_pkg::*; #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  logic [NUMBER_WIDTH-1:0] q_mag,
  input  itrt_cmd_t               q_cmd,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CHAR_W-1:0]       out_text_char,
  output logic                    out_last_char
);

  localparam int IDX_W = $clog2(NUMBER_WIDTH);
  localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);
  localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(NUMBER_WIDTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(NUMBER_WIDTH);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  back_state_t state_r, state_nxt;

  logic [NUMBER_WIDTH-1:0] mag_r, mag_nxt;
  logic [RADIX_W-1:0]      rem_r, rem_nxt;
  logic [IDX_W-1:0]        step_r, step_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  itrt_cmd_t               cmd_r, cmd_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]       out_char_r, out_char_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [DIGIT_W-1:0]      stack [NUMBER_WIDTH];
  logic [DIGIT_W-1:0]      rd_data_r;
  logic [CNT_W-1:0]        cnt_dec;
  logic [CNT_W-1:0]        cnt_inc;

  // one restoring-division step per cycle
  logic [RADIX_W-1:0]      rem_sh;
  logic                    ge;
  logic [RADIX_W-1:0]      rem_new;
  logic [NUMBER_WIDTH-1:0] mag_new;
  logic                    digit_done;
  logic                    wr_en;
  logic                    out_free;

  assign rem_sh  = {rem_r[RADIX_W-2:0], mag_r[NUMBER_WIDTH-1]};
  assign ge      = (rem_sh >= cmd_r.base);
  assign rem_new = ge ? (rem_sh - cmd_r.base) : rem_sh;
  assign mag_new = {mag_r[NUMBER_WIDTH-2:0], ge};
  assign cnt_dec = cnt_r - CNT_ONE;
  assign cnt_inc = cnt_r + CNT_ONE;

  assign digit_done = (state_r == BK_DIV) && (step_r == STEP_LAST);
  assign wr_en      = digit_done;
  assign out_free   = !out_valid_r || !out_stall;
  assign q_pop      = (state_r == BK_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (digit_done && ((mag_new == '0) || (cnt_inc == CNT_FULL))) begin
          state_nxt = cmd_r.neg ? BK_SIGN : BK_READ;
        end
      end
      BK_SIGN: begin
        if (out_free) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          state_nxt = (cnt_r == CNT_ONE) ? BK_IDLE : BK_READ;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          mag_nxt  = q_mag;
          cmd_nxt  = q_cmd;
          rem_nxt  = '0;
          step_nxt = '0;
          cnt_nxt  = '0;
        end
      end
      BK_DIV: begin
        mag_nxt  = mag_new;
        rem_nxt  = rem_new;
        step_nxt = step_r + 1'b1;
        if (digit_done) begin
          rem_nxt  = '0;
          step_nxt = '0;
          cnt_nxt  = cnt_inc;
        end
      end
      BK_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(rd_data_r, cmd_r.lower);
          out_last_nxt  = (cnt_r == CNT_ONE);
          cnt_nxt       = cnt_dec;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      step_r      <= '0;
      mag_r       <= '0;
      cmd_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      mag_r       <= mag_nxt;
      cmd_r       <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // digit stack, least significant digit at entry 0
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack[cnt_r[IDX_W-1:0]] <= rem_new[DIGIT_W-1:0];
    end
    if (state_r == BK_READ) begin
      rd_data_r <= stack[cnt_dec[IDX_W-1:0]];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;

endmodule

### rtl/integer_to_radix_text_unit.sv
`timescale 1ns / 1ps
// Integer to radix text converter.
// Input channel (in_valid / in_stall): one number word, a base (clamped to
// 2..16) and format flags (bit0 unsigned, bit1 lowercase letters).
// Output channel (out_valid / out_stall): the number as ASCII characters,
// most significant first, '-' first for a negative signed value, with
// out_last_char high on the final character.
// The front end sign-classifies and clamps the item and drops it into a
// two-entry queue, so up to two items wait while one is being converted.
// Each digit is computed in the shared one-bit-per-cycle restoring divider;
// each digit character is then a digit stack read followed by an output
// load, and the sign is a single output load. A stalled output holds its
// character and the converter waits. Reset empties the queue and the
// output register; no clearing pass.
module integer_to_radix_text_unit import itrt_pkg::*; #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_number_bits,
  input  logic [RADIX_W-1:0] in_radix,
  input  logic [1:0]         in_format_flags,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  out_text_char,
  output logic               out_last_char
);

  localparam int CMD_W = $bits(itrt_cmd_t);
  localparam int Q_W   = NUMBER_WIDTH + CMD_W;

  logic [NUMBER_WIDTH-1:0] f_mag;
  itrt_cmd_t               f_cmd;
  logic                    q_full;
  logic                    q_push;
  logic                    q_pop;
  logic                    q_valid;
  logic [Q_W-1:0]          q_data;
  itrt_cmd_t               q_cmd;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_cmd    = itrt_cmd_t'(q_data[CMD_W-1:0]);

  itrt_front #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_front (
    .number_bits  (in_number_bits),
    .radix        (in_radix),
    .format_flags (in_format_flags),
    .mag          (f_mag),
    .cmd          (f_cmd)
  );

  itrt_queue #(.DATA_W(Q_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_mag, f_cmd}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  itrt_back #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_mag         (q_data[Q_W-1:CMD_W]),
    .q_cmd         (q_cmd),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

endmodule

### rtl/itrt_checker.sv
`timescale 1ns / 1ps
module itrt_checker import itrt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAR_W-1:0] out_text_char,
  input logic              out_last_char
);

  // reset leaves the queue empty and nothing on the output
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("output or input stall not clear after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output item dropped while stalled");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_text_char == CHAR_MINUS) ||
                   ((out_text_char >= 8'h30) && (out_text_char <= 8'h39)) ||
                   ((out_text_char >= 8'h41) && (out_text_char <= 8'h46)) ||
                   ((out_text_char >= 8'h61) && (out_text_char <= 8'h66))))
    else $error("character outside the digit set");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_text_char == CHAR_MINUS) |-> !out_last_char)
    else $error("sign marked as last character");

endmodule

bind integer_to_radix_text_unit itrt_checker u_itrt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_text_char (out_text_char),
  .out_last_char (out_last_char)
);

### tb/sv/integer_to_radix_text_unit_test.sv
`timescale 1ns / 1ps
module integer_to_radix_text_unit_test;
  import itrt_pkg::*;

  localparam int NW = 32;
  localparam logic [63:0] NUM_MASK = (64'd1 << NW) - 64'd1;
  localparam int RANDOM_ITEMS = 128;
  localparam int HOLD_AT = 30;
  localparam int PAUSE_AT = 80;
  localparam int QUIET_FROM = 110;
  localparam int LONG_HOLD = 4000;
  localparam int DRAIN_CYCLES = 1200;
  localparam int CYCLE_LIMIT = 900_000;

  localparam logic [1:0] FMT_SIGNED_UP    = 2'b00;
  localparam logic [1:0] FMT_UNSIGNED_UP  = 2'b01;
  localparam logic [1:0] FMT_SIGNED_LOW   = 2'b10;
  localparam logic [1:0] FMT_UNSIGNED_LOW = 2'b11;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  class char_ledger;
    text_char_t pending_chars[$];
    int errors = 0;

    function int pending();
      return pending_chars.size();
    endfunction

    // expands one accepted number into the characters it must print
    function void note_number(logic [31:0] bits, logic [RADIX_W-1:0] radix,
                              logic [1:0] flags);
      logic [63:0] mag;
      logic [63:0] base;
      logic [DIGIT_W-1:0] digits[$];
      logic neg;
      logic [CHAR_W-1:0] letter_a;
      logic [CHAR_W-1:0] c;
      base = (radix < RADIX_MIN) ? 64'(RADIX_MIN) :
             (radix > RADIX_MAX) ? 64'(RADIX_MAX) : 64'(radix);
      mag = 64'(bits) & NUM_MASK;
      neg = !flags[FLAG_UNSIGNED] && mag[NW-1];
      if (neg) mag = (64'd0 - mag) & NUM_MASK;
      letter_a = flags[FLAG_LOWER] ? CHAR_LOW_A : CHAR_UP_A;
      do begin
        digits.push_front(DIGIT_W'(mag % base));
        mag = mag / base;
      end while (mag != 0 && digits.size() < NW);
      if (neg) pending_chars.push_back('{CHAR_MINUS, 1'b0});
      foreach (digits[i]) begin
        if (digits[i] < 10) c = CHAR_ZERO + CHAR_W'(digits[i]);
        else c = letter_a + CHAR_W'(digits[i]) - 8'd10;
        pending_chars.push_back('{c, i == digits.size() - 1});
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected item text_char %h last_char %b", $time, ch, last);
        return;
      end
      want = pending_chars.pop_front();
      if (want.ch !== ch) begin
        errors++;
        $display("%0t: text_char expected %h actual %h", $time, want.ch, ch);
      end
      if (want.last !== last) begin
        errors++;
        $display("%0t: last_char expected %b actual %b", $time, want.last, last);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        in_number_bits = '0;
  logic [RADIX_W-1:0] in_radix = RADIX_MIN;
  logic [1:0]         in_format_flags = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  out_text_char;
  logic               out_last_char;

  bit quiet = 1'b0;
  bit hold_pending = 1'b0;
  char_ledger ledger = new();

  integer_to_radix_text_unit #(.NUMBER_WIDTH(NW)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_number_bits(in_number_bits),
    .in_radix(in_radix),
    .in_format_flags(in_format_flags),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_text_char(out_text_char),
    .out_last_char(out_last_char)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.check_char(out_text_char, out_last_char);
  end

  // receiver side: random stall bursts, one long hold-off on request
  initial begin : sink
    wait (rst_n);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_number(input logic [31:0] num, input logic [RADIX_W-1:0] radix,
                             input logic [1:0] flags);
    int gap;
    in_valid <= 1'b1;
    in_number_bits <= num;
    in_radix <= radix;
    in_format_flags <= flags;
    do @(posedge clk); while (in_stall);
    ledger.note_number(num, radix, flags);
    gap = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_number();
    logic [31:0] num;
    logic [RADIX_W-1:0] radix;
    num = $urandom();
    case ($urandom_range(0, 9))
      0, 1: num = $urandom_range(0, 300);
      2: num = 32'd0 - 32'($urandom_range(1, 300));
      3: begin
        case ($urandom_range(0, 3))
          0: num = 32'h0000_0000;
          1: num = 32'h8000_0000;
          2: num = 32'hffff_ffff;
          default: num = 32'h7fff_ffff;
        endcase
      end
      default: ;
    endcase
    radix = ($urandom_range(0, 9) == 0) ? RADIX_W'($urandom_range(0, 31))
                                         : RADIX_W'($urandom_range(2, 16));
    send_number(num, radix, 2'($urandom_range(0, 3)));
  endtask

  initial begin : main
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero, extremes, sign handling, letter case, base clamping
    send_number(32'd0, 5'd10, FMT_SIGNED_UP);
    send_number(32'd0, 5'd2, FMT_UNSIGNED_LOW);
    send_number(32'h8000_0000, 5'd2, FMT_SIGNED_UP);
    send_number(32'h8000_0000, 5'd10, FMT_SIGNED_LOW);
    send_number(32'hffff_ffff, 5'd2, FMT_UNSIGNED_UP);
    send_number(32'hffff_ffff, 5'd10, FMT_SIGNED_UP);
    send_number(32'hffff_ffff, 5'd16, FMT_UNSIGNED_UP);
    send_number(32'hffff_ffff, 5'd16, FMT_UNSIGNED_LOW);
    send_number(32'h7fff_ffff, 5'd10, FMT_SIGNED_UP);
    send_number(32'hdead_beef, 5'd16, FMT_SIGNED_UP);
    send_number(32'hdead_beef, 5'd16, FMT_SIGNED_LOW);
    send_number(32'h00ab_cdef, 5'd16, FMT_UNSIGNED_LOW);
    send_number(32'd12345, 5'd0, FMT_SIGNED_UP);
    send_number(32'd12345, 5'd1, FMT_UNSIGNED_UP);
    send_number(32'd12345, 5'd17, FMT_SIGNED_LOW);
    send_number(32'd12345, 5'd31, FMT_UNSIGNED_LOW);
    send_number(32'hffff_ffff, 5'd31, FMT_UNSIGNED_LOW);
    send_number(32'd35, 5'd3, FMT_SIGNED_UP);
    send_number(32'd255, 5'd8, FMT_UNSIGNED_UP);
    send_number(32'hffff_ff85, 5'd7, FMT_SIGNED_LOW);
    send_number(32'd1, 5'd16, FMT_SIGNED_UP);
    send_number(32'd15, 5'd16, FMT_UNSIGNED_LOW);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) hold_pending = 1'b1;
      if (i == PAUSE_AT) begin
        in_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge clk);
      end
      if (i == QUIET_FROM) quiet = 1'b1;
      send_random_number();
    end
    in_valid <= 1'b0;

    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
